// ----- hw/rtl/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescaper.
// Used by the front parser, the job queue, the back emitter and the top level.
`timescale 1ns / 1ps

package jsu_pkg;

  // Parser phase of the front end
  typedef enum logic [2:0] {
    PH_AWAIT = 3'd0,
    PH_BODY  = 3'd1,
    PH_ESC   = 3'd2,
    PH_HEX1  = 3'd3,
    PH_LOWBS = 3'd4,
    PH_LOWU  = 3'd5,
    PH_HEX2  = 3'd6,
    PH_DRAIN = 3'd7
  } phase_t;

  // Final status codes of a string
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_QUOTE    = 3'd1,
    ST_CTRL     = 3'd2,
    ST_BADESC   = 3'd3,
    ST_BADUNI   = 3'd4,
    ST_UNPAIRED = 3'd5,
    ST_INVALID  = 3'd6,
    ST_UNTERM   = 3'd7
  } status_t;

  localparam int unsigned MAX_BYTES = 4;

  // Work for the back end caused by one input beat: up to four data
  // bytes, then an optional status result
  typedef struct packed {
    logic [2:0]                 nb;
    logic [MAX_BYTES-1:0][7:0]  bytes;
    logic                       st_vld;
    status_t                    code;
  } job_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_U     = 8'h75;

endpackage

// ----- hw/rtl/jsu_front.sv -----
// Front end of the JSON string unescaper: parses input bytes, tracks UTF-8
// validity and turns each accepted beat into one job. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    in_byte,
  input  logic          in_eoi,
  output jsu_pkg::job_t job
);
  import jsu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [9:0]  hs_r, hs_nxt;
  logic        pend_r, pend_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic [1:0]  len_r, len_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic        fault_r, fault_nxt;

  logic        hv_ok;
  logic [3:0]  hv;
  logic        esc_ok;
  logic [7:0]  esc_byte;
  logic [15:0] acc_new;
  logic        hi_sur, lo_sur;
  logic [20:0] cp_pair;
  logic [20:0] cp_chk;
  job_t        enc_bmp, enc_pair;

  // Encode one code point as UTF-8 bytes
  function automatic job_t enc(input logic [20:0] c);
    job_t j;
    j = '0;
    if (c <= 21'h7f) begin
      j.nb = 3'd1;
      j.bytes[0] = c[7:0];
    end else if (c <= 21'h7ff) begin
      j.nb = 3'd2;
      j.bytes[0] = {3'b110, c[10:6]};
      j.bytes[1] = {2'b10, c[5:0]};
    end else if (c <= 21'hffff) begin
      j.nb = 3'd3;
      j.bytes[0] = {4'b1110, c[15:12]};
      j.bytes[1] = {2'b10, c[11:6]};
      j.bytes[2] = {2'b10, c[5:0]};
    end else begin
      j.nb = 3'd4;
      j.bytes[0] = {5'b11110, c[20:18]};
      j.bytes[1] = {2'b10, c[17:12]};
      j.bytes[2] = {2'b10, c[11:6]};
      j.bytes[3] = {2'b10, c[5:0]};
    end
    return j;
  endfunction

  // Decode a hex digit; a bad digit reads as zero
  always_comb begin
    hv_ok = 1'b0;
    hv    = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hv_ok = 1'b1;
      hv    = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hv_ok = 1'b1;
      hv    = in_byte[3:0] + 4'd9;
    end
  end

  // Map simple escape letters
  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte;
    unique case (in_byte)
      8'h22, 8'h5c, 8'h2f: esc_byte = in_byte;
      8'h62: esc_byte = 8'h08;
      8'h66: esc_byte = 8'h0c;
      8'h6e: esc_byte = 8'h0a;
      8'h72: esc_byte = 8'h0d;
      8'h74: esc_byte = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  assign acc_new  = {acc_r, hv};
  assign hi_sur   = (acc_new[15:10] == 6'b110110);
  assign lo_sur   = (acc_new[15:10] == 6'b110111);
  assign cp_pair  = 21'h10000 + {1'b0, hs_r, acc_new[9:0]};
  assign enc_bmp  = enc({5'd0, acc_new});
  assign enc_pair = enc(cp_pair);

  // Output decode: the job this beat causes
  always_comb begin
    job = '0;
    unique case (phase_r)
      PH_AWAIT: begin
        if (in_byte != CH_QUOTE) begin
          job.st_vld = 1'b1; job.code = ST_QUOTE;
        end else if (in_eoi) begin
          job.st_vld = 1'b1; job.code = ST_UNTERM;
        end
      end
      PH_BODY: begin
        if (in_byte == CH_QUOTE) begin
          job.st_vld = 1'b1;
          job.code   = (fault_r || rem_r != 2'd0) ? ST_INVALID : ST_OK;
        end else if (in_byte < 8'h20) begin
          job.st_vld = 1'b1; job.code = ST_CTRL;
        end else if (in_byte == CH_BSL) begin
          if (in_eoi) begin
            job.st_vld = 1'b1; job.code = ST_BADESC;
          end
        end else begin
          job.nb = 3'd1;
          job.bytes[0] = in_byte;
          if (in_eoi) begin
            job.st_vld = 1'b1; job.code = ST_UNTERM;
          end
        end
      end
      PH_ESC: begin
        if (esc_ok) begin
          job.nb = 3'd1;
          job.bytes[0] = esc_byte;
          if (in_eoi) begin
            job.st_vld = 1'b1; job.code = ST_UNTERM;
          end
        end else if (in_byte == CH_U) begin
          if (in_eoi) begin
            job.st_vld = 1'b1; job.code = ST_BADUNI;
          end
        end else begin
          job.st_vld = 1'b1; job.code = ST_BADESC;
        end
      end
      PH_HEX1: begin
        if (!hv_ok) begin
          job.st_vld = 1'b1; job.code = ST_BADUNI;
        end else if (cnt_r != 2'd3) begin
          if (in_eoi) begin
            job.st_vld = 1'b1; job.code = ST_BADUNI;
          end
        end else if (hi_sur) begin
          if (in_eoi) begin
            job.st_vld = 1'b1; job.code = ST_UNPAIRED;
          end
        end else if (lo_sur) begin
          job.st_vld = 1'b1; job.code = ST_UNPAIRED;
        end else begin
          job.nb    = enc_bmp.nb;
          job.bytes = enc_bmp.bytes;
          if (in_eoi) begin
            job.st_vld = 1'b1; job.code = ST_UNTERM;
          end
        end
      end
      PH_LOWBS: begin
        if (in_byte != CH_BSL || in_eoi) begin
          job.st_vld = 1'b1; job.code = ST_UNPAIRED;
        end
      end
      PH_LOWU: begin
        if (in_byte != CH_U || in_eoi) begin
          job.st_vld = 1'b1; job.code = ST_UNPAIRED;
        end
      end
      PH_HEX2: begin
        if (cnt_r != 2'd3) begin
          if (in_eoi) begin
            job.st_vld = 1'b1; job.code = ST_UNPAIRED;
          end
        end else if (pend_r || !hv_ok) begin
          job.st_vld = 1'b1; job.code = ST_BADUNI;
        end else if (!lo_sur) begin
          job.st_vld = 1'b1; job.code = ST_UNPAIRED;
        end else begin
          job.nb    = enc_pair.nb;
          job.bytes = enc_pair.bytes;
          if (in_eoi) begin
            job.st_vld = 1'b1; job.code = ST_UNTERM;
          end
        end
      end
      PH_DRAIN: begin
        job = '0;
      end
      default: job = '0;
    endcase
  end

  // Next state of the parser and the UTF-8 checker
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    hs_nxt    = hs_r;
    pend_nxt  = pend_r;
    rem_nxt   = rem_r;
    len_nxt   = len_r;
    cp_nxt    = cp_r;
    fault_nxt = fault_r;
    cp_chk    = {cp_r[14:0], in_byte[5:0]};

    unique case (phase_r)
      PH_AWAIT: begin
        if (in_byte == CH_QUOTE) begin
          cnt_nxt = '0; acc_nxt = '0; hs_nxt = '0; pend_nxt = 1'b0;
          rem_nxt = '0; len_nxt = '0; cp_nxt = '0; fault_nxt = 1'b0;
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        if (in_byte == CH_BSL && !in_eoi) phase_nxt = PH_ESC;
      end
      PH_ESC: begin
        if (esc_ok) begin
          phase_nxt = PH_BODY;
        end else if (in_byte == CH_U) begin
          cnt_nxt = '0; acc_nxt = '0;
          phase_nxt = PH_HEX1;
        end
      end
      PH_HEX1: begin
        if (hv_ok) begin
          acc_nxt = acc_new[11:0];
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            if (hi_sur) begin
              hs_nxt    = acc_new[9:0];
              phase_nxt = PH_LOWBS;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        end
      end
      PH_LOWBS: phase_nxt = PH_LOWU;
      PH_LOWU: begin
        cnt_nxt = '0; acc_nxt = '0; pend_nxt = 1'b0;
        phase_nxt = PH_HEX2;
      end
      PH_HEX2: begin
        pend_nxt = pend_r | ~hv_ok;
        acc_nxt  = acc_new[11:0];
        cnt_nxt  = cnt_r + 2'd1;
        if (cnt_r == 2'd3) phase_nxt = PH_BODY;
      end
      PH_DRAIN: begin
        if (in_eoi) begin
          cnt_nxt = '0; acc_nxt = '0; hs_nxt = '0; pend_nxt = 1'b0;
          rem_nxt = '0; len_nxt = '0; cp_nxt = '0; fault_nxt = 1'b0;
          phase_nxt = PH_AWAIT;
        end
      end
      default: phase_nxt = PH_DRAIN;
    endcase

    // Check emitted bytes: a raw byte steps the checker, an escape is
    // already well formed and only faults inside an open sequence
    if (job.nb != 3'd0 && !fault_r) begin
      if (phase_r == PH_BODY) begin
        if (rem_r == 2'd0) begin
          if (in_byte[7] == 1'b0) begin
            fault_nxt = 1'b0;
          end else if (in_byte[7:5] == 3'b110) begin
            cp_nxt = {16'd0, in_byte[4:0]};
            if (in_byte[4:0] == 5'd0) begin
              fault_nxt = 1'b1;
            end else begin
              len_nxt = 2'd1; rem_nxt = 2'd1;
            end
          end else if (in_byte[7:4] == 4'b1110) begin
            cp_nxt = {17'd0, in_byte[3:0]}; len_nxt = 2'd2; rem_nxt = 2'd2;
          end else if (in_byte[7:3] == 5'b11110) begin
            cp_nxt = {18'd0, in_byte[2:0]}; len_nxt = 2'd3; rem_nxt = 2'd3;
          end else begin
            fault_nxt = 1'b1;
          end
        end else if (in_byte[7:6] != 2'b10) begin
          fault_nxt = 1'b1;
        end else begin
          cp_nxt  = cp_chk;
          rem_nxt = rem_r - 2'd1;
          if (rem_r == 2'd1) begin
            if ((len_r == 2'd1 && cp_chk < 21'h80) ||
                (len_r == 2'd2 && cp_chk < 21'h800) ||
                (len_r == 2'd3 && cp_chk < 21'h10000) ||
                cp_chk > 21'h10ffff ||
                (cp_chk >= 21'hd800 && cp_chk <= 21'hdfff))
              fault_nxt = 1'b1;
          end
        end
      end else if (rem_r != 2'd0) begin
        fault_nxt = 1'b1;
      end
    end

    // A status ends the string: clear on end of input, else drain
    if (job.st_vld) begin
      if (in_eoi) begin
        cnt_nxt = '0; acc_nxt = '0; hs_nxt = '0; pend_nxt = 1'b0;
        rem_nxt = '0; len_nxt = '0; cp_nxt = '0; fault_nxt = 1'b0;
        phase_nxt = PH_AWAIT;
      end else begin
        phase_nxt = PH_DRAIN;
      end
    end
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_AWAIT;
      cnt_r   <= '0;
      acc_r   <= '0;
      hs_r    <= '0;
      pend_r  <= 1'b0;
      rem_r   <= '0;
      len_r   <= '0;
      cp_r    <= '0;
      fault_r <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      hs_r    <= hs_nxt;
      pend_r  <= pend_nxt;
      rem_r   <= rem_nxt;
      len_r   <= len_nxt;
      cp_r    <= cp_nxt;
      fault_r <= fault_nxt;
    end
  end

endmodule

// ----- hw/rtl/jsu_fifo.sv -----
// Short job queue between the front parser and the back emitter.
// Depends on jsu_pkg for the job type.
`timescale 1ns / 1ps

module jsu_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::job_t wdata,
  input  logic          pop,
  output jsu_pkg::job_t rdata,
  output logic          full,
  output logic          empty
);
  import jsu_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rp_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ----- hw/rtl/jsu_back.sv -----
// Back end of the JSON string unescaper: expands each job into result beats,
// one per cycle unless stalled, through an output register. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jsu_pkg::job_t    head,
  input  logic             head_vld,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_byte,
  output logic             out_is_status,
  output jsu_pkg::status_t out_status,
  output logic             out_last
);
  import jsu_pkg::*;

  logic       vld_r;
  logic [7:0] byte_r;
  logic       sts_r;
  status_t    code_r;
  logic       last_r;
  logic [2:0] idx_r;

  logic [2:0] total;
  logic       load;
  logic       is_data;
  logic       beat_last;

  assign total     = head.nb + {2'd0, head.st_vld};
  assign load      = head_vld && (!vld_r || out_tready);
  assign is_data   = (idx_r < head.nb);
  assign beat_last = (idx_r == total - 3'd1);
  assign pop       = load && beat_last;

  assign out_tvalid    = vld_r;
  assign out_byte      = byte_r;
  assign out_is_status = sts_r;
  assign out_status    = code_r;
  assign out_last      = last_r;

  // Hold the output beat until taken; load the next one from the head job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      vld_r <= 1'b1;
      idx_r <= beat_last ? 3'd0 : idx_r + 3'd1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= is_data ? head.bytes[idx_r[1:0]] : 8'd0;
      sts_r  <= ~is_data;
      code_r <= is_data ? ST_OK : head.code;
      last_r <= beat_last;
    end
  end

endmodule

// ----- hw/rtl/json_string_unescaper_top.sv -----
// Top level of the JSON string unescaper: front parser, job queue and back
// emitter. Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
`timescale 1ns / 1ps

// The block takes one input byte per cycle while the job queue has room.
// Each accepted beat becomes one job of zero to five result beats (up to
// four UTF-8 bytes from an escape, then a final status); the back end sends
// one result beat per cycle while out_tready is high, so a \u escape that
// encodes to several bytes makes a burst of beats; the FIFO_DEPTH-entry queue
// absorbs such bursts before input backpressure sets in. A result is stored
// in the job queue, then in the back end's output register. Results with
// is_status set end a string; bytes before an error status are provisional,
// and input is dropped up to and including the next beat with tlast set.
module json_string_unescaper_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic        out_tuser,  // is_status
  output logic        out_tlast   // last
);
  import jsu_pkg::*;

  job_t    fjob, hjob;
  logic    in_fire, push, pop, full, empty;
  logic [7:0] obyte;
  status_t    ocode;

  assign in_tready = ~full;
  assign in_fire   = in_tvalid && in_tready;
  assign push      = in_fire && (fjob.nb != 3'd0 || fjob.st_vld);

  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_eoi  (in_tlast),
    .job     (fjob)
  );

  jsu_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (fjob),
    .pop   (pop),
    .rdata (hjob),
    .full  (full),
    .empty (empty)
  );

  jsu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (hjob),
    .head_vld      (~empty),
    .pop           (pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_byte      (obyte),
    .out_is_status (out_tuser),
    .out_status    (ocode),
    .out_last      (out_tlast)
  );

  // Pack the result beat
  assign out_tdata = {5'd0, ocode, obyte};

endmodule
